>>> rtl/bft_pkg.sv
`default_nettype none

package bft_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned CountW = 24;
  localparam int unsigned MsW    = 16;
  localparam int unsigned SleptW = 17;
  localparam int unsigned CfgW   = 24;

  localparam logic [CountW-1:0] MinWaterMark = CountW'(376);

  localparam logic [CountW-1:0] MaxWaterMarkRst = CountW'(200000);
  localparam logic [MsW-1:0]    TimeoutRst      = MsW'(100);
  localparam logic [MsW-1:0]    DataIntervalRst = MsW'(40);
  localparam logic [MsW-1:0]    SleepStepRst    = MsW'(20);

  typedef enum logic [1:0] {
    CFG_MAX_WATER_MARK = 2'd0,
    CFG_TIMEOUT        = 2'd1,
    CFG_DATA_INTERVAL  = 2'd2,
    CFG_SLEEP_STEP     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_READY = 3'b001,
    MODE_SLEEP = 3'b010,
    MODE_WRAP  = 3'b100
  } mode_e;

  localparam logic FUNC_FILL    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

endpackage

`default_nettype wire

>>> rtl/buffer_fill_throttle_top.sv
// path: a request is held in the input register, then its result in the result register
// throughput: one request per cycle; a stalled result holds the input register and tready
// the state update (mode, watermark, median taps) is one combinational pass per request
// reset: asynchronous, active low; mode ready, low watermark and registers at defaults,
// median taps invalid, both stream sides empty
`default_nettype none

module buffer_fill_throttle_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_data_i,
  // request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [55:0] s_axis_tdata_i,   // [31:0] buf_addr, [55:32] fill_count
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] func
  // result stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o    // [0] may_process, [1] sleep_request, rest zero
);

  localparam int unsigned AW = bft_pkg::AddrW;
  localparam int unsigned CW = bft_pkg::CountW;
  localparam int unsigned MW = bft_pkg::MsW;
  localparam int unsigned SW = bft_pkg::SleptW;

  // configuration registers
  logic [CW-1:0] max_wm_q;
  logic [MW-1:0] timeout_q, data_int_q, step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_wm_q   <= bft_pkg::MaxWaterMarkRst;
      timeout_q  <= bft_pkg::TimeoutRst;
      data_int_q <= bft_pkg::DataIntervalRst;
      step_q     <= bft_pkg::SleepStepRst;
    end else if (cfg_we_i) begin
      unique case (bft_pkg::cfg_idx_e'(cfg_idx_i))
        bft_pkg::CFG_MAX_WATER_MARK: max_wm_q   <= cfg_data_i[CW-1:0];
        bft_pkg::CFG_TIMEOUT:        timeout_q  <= cfg_data_i[MW-1:0];
        bft_pkg::CFG_DATA_INTERVAL:  data_int_q <= cfg_data_i[MW-1:0];
        bft_pkg::CFG_SLEEP_STEP:     step_q     <= cfg_data_i[MW-1:0];
        default: ;
      endcase
    end
  end

  // input register and result register handshake
  logic          in_vld_q, out_vld_q;
  logic          func_q;
  logic [AW-1:0] addr_q;
  logic [CW-1:0] count_q;
  logic          may_q, slp_q;
  logic          out_free, adv;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign adv             = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      addr_q  <= s_axis_tdata_i[AW-1:0];
      count_q <= s_axis_tdata_i[AW+CW-1:AW];
      func_q  <= s_axis_tuser_i[0];
    end
  end

  // block state
  bft_pkg::mode_e mode_q, mode_d;
  logic [CW-1:0]  low_water_q, low_water_d;
  logic [CW-1:0]  prev_count_q, prev_count_d;
  logic [AW-1:0]  prev_addr_q, prev_addr_d;
  logic [SW-1:0]  slept_q, slept_d;
  logic [CW-1:0]  tap_one_q, tap_one_d, tap_two_q, tap_two_d;
  logic [1:0]     taps_valid_q, taps_valid_d;
  logic           may_d, slp_d;

  // arithmetic on the registered request
  logic [MW-1:0]   interval;
  logic [SW:0]     slept_sum;
  logic [SW-1:0]   slept_sat;
  logic [CW+1:0]   growth;
  logic            grow_gt_max;
  logic [CW+1:0]   lw_upper;
  logic [CW-1:0]   lw_clip;
  logic [CW-1:0]   med_lo, med_mid, med_hi, med_out;
  logic [AW:0]     end_now, end_prev;
  logic            unchanged, relearn;

  always_comb begin
    interval    = (data_int_q < timeout_q) ? data_int_q : timeout_q;
    slept_sum   = {1'b0, slept_q} + {{(SW+1-MW){1'b0}}, step_q};
    slept_sat   = slept_sum[SW] ? {SW{1'b1}} : slept_sum[SW-1:0];
    growth      = {2'b00, count_q} - {2'b00, prev_count_q};
    grow_gt_max = $signed(growth) > $signed({2'b00, max_wm_q});
    lw_upper    = grow_gt_max ? {2'b00, max_wm_q} : growth;
    // lower clip last, so it wins over a small max_water_mark
    lw_clip     = ($signed(lw_upper) < $signed({2'b00, bft_pkg::MinWaterMark}))
                  ? bft_pkg::MinWaterMark : lw_upper[CW-1:0];
    // three-tap median
    med_lo      = (lw_clip < tap_one_q) ? lw_clip : tap_one_q;
    med_hi      = (lw_clip > tap_one_q) ? lw_clip : tap_one_q;
    med_mid     = (med_lo > tap_two_q) ? med_lo : tap_two_q;
    med_out     = (taps_valid_q == 2'b11) ? ((med_mid < med_hi) ? med_mid : med_hi)
                                          : lw_clip;
    end_now     = {1'b0, addr_q} + {{(AW+1-CW){1'b0}}, count_q};
    end_prev    = {1'b0, prev_addr_q} + {{(AW+1-CW){1'b0}}, prev_count_q};
    unchanged   = (count_q == prev_count_q) && (addr_q == prev_addr_q);
    relearn     = (slept_sat >= {1'b0, timeout_q}) || grow_gt_max;
  end

  always_comb begin
    mode_d       = mode_q;
    low_water_d  = low_water_q;
    prev_count_d = prev_count_q;
    prev_addr_d  = prev_addr_q;
    slept_d      = slept_q;
    tap_one_d    = tap_one_q;
    tap_two_d    = tap_two_q;
    taps_valid_d = taps_valid_q;
    may_d        = 1'b0;
    slp_d        = 1'b0;
    if (func_q == bft_pkg::FUNC_RESTART) begin
      mode_d       = bft_pkg::MODE_READY;
      low_water_d  = max_wm_q;
      taps_valid_d = 2'b00;
    end else begin
      unique case (mode_q)
        bft_pkg::MODE_SLEEP: begin
          slept_d = slept_sat;
          if ((slept_sat >= {1'b0, interval}) && unchanged) begin
            mode_d = bft_pkg::MODE_WRAP;
            may_d  = 1'b1;
          end else begin
            if (relearn) begin
              low_water_d  = med_out;
              tap_two_d    = tap_one_q;
              tap_one_d    = lw_clip;
              taps_valid_d = {taps_valid_q[0], 1'b1};
              mode_d       = bft_pkg::MODE_READY;
            end
            slp_d = 1'b1;
          end
        end
        bft_pkg::MODE_WRAP: begin
          if (end_now != end_prev) begin
            mode_d = bft_pkg::MODE_READY;
          end else begin
            prev_addr_d  = addr_q;
            prev_count_d = count_q;
            may_d        = 1'b1;
          end
        end
        default: begin
          if (count_q < low_water_q) begin
            prev_count_d = count_q;
            prev_addr_d  = addr_q;
            mode_d       = bft_pkg::MODE_SLEEP;
            slept_d      = '0;
            slp_d        = 1'b1;
          end else begin
            may_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= bft_pkg::MODE_READY;
      low_water_q  <= bft_pkg::MaxWaterMarkRst;
      prev_count_q <= '0;
      prev_addr_q  <= '0;
      slept_q      <= '0;
      tap_one_q    <= '0;
      tap_two_q    <= '0;
      taps_valid_q <= 2'b00;
      out_vld_q    <= 1'b0;
    end else begin
      if (adv) begin
        mode_q       <= mode_d;
        low_water_q  <= low_water_d;
        prev_count_q <= prev_count_d;
        prev_addr_q  <= prev_addr_d;
        slept_q      <= slept_d;
        tap_one_q    <= tap_one_d;
        tap_two_q    <= tap_two_d;
        taps_valid_q <= taps_valid_d;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      may_q <= may_d;
      slp_q <= slp_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b000000, slp_q, may_q};

  // a result never asks to both process and sleep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(may_q && slp_q))
    else $error("result has both may_process and sleep_request");

  // the second tap is only valid once the first one is
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    taps_valid_q[1] |-> taps_valid_q[0])
    else $error("median tap valid bits out of order");

  // a pending request always reaches the result register when it is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("request lost between input and result register");

  // a fill request that asks for sleep from ready mode enters sleep mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (func_q == bft_pkg::FUNC_FILL) && (mode_q == bft_pkg::MODE_READY) && slp_d)
    |=> (mode_q == bft_pkg::MODE_SLEEP))
    else $error("sleep request from ready mode did not enter sleep");

endmodule

`default_nettype wire

>>> verif/buffer_fill_throttle_top_tb.sv
`timescale 1ns / 1ps

module buffer_fill_throttle_top_tb;

  typedef struct packed {
    logic may;
    logic slp;
  } decision_t;

  // directed rows: typed = 1 means the decision is spelled out, else predicted
  typedef struct packed {
    logic        func;
    logic [31:0] addr;
    logic [23:0] count;
    logic        typed;
    logic        may;
    logic        slp;
  } dir_row_t;

  localparam int NumDir = 24;
  localparam dir_row_t DirTbl [NumDir] = '{
    '{bft_pkg::FUNC_FILL,    32'h0000_0000, 24'hFFFFFF, 1'b1, 1'b1, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'hFFFF_FFFF, 24'd200000, 1'b1, 1'b1, 1'b0},
    '{bft_pkg::FUNC_RESTART, 32'hFFFF_FFFF, 24'hFFFFFF, 1'b1, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_1000, 24'd199999, 1'b1, 1'b0, 1'b1},
    '{bft_pkg::FUNC_FILL,    32'h0000_1000, 24'd199999, 1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_1000, 24'd199999, 1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_1100, 24'd199743, 1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_1100, 24'd199744, 1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_2000, 24'd100,    1'b1, 1'b0, 1'b1},
    '{bft_pkg::FUNC_FILL,    32'h0000_2004, 24'd150,    1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_2008, 24'd200,    1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_200C, 24'd250,    1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_2010, 24'd300,    1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_2014, 24'd50,     1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_0000, 24'd375,    1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_0000, 24'hFFFFFF, 1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_0000, 24'd0,      1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_0005, 24'd1000,   1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_0005, 24'd2000,   1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_0005, 24'd3000,   1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_0005, 24'd4000,   1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_0005, 24'd5000,   1'b0, 1'b0, 1'b0},
    '{bft_pkg::FUNC_RESTART, 32'h0000_0000, 24'd0,      1'b1, 1'b0, 1'b0},
    '{bft_pkg::FUNC_FILL,    32'h0000_0000, 24'd199999, 1'b1, 1'b0, 1'b1}
  };

  localparam int NumPhases     = 8;
  localparam int ReqsPerPhase  = 144;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  bft_pkg::cfg_idx_e cfg_idx = bft_pkg::CFG_MAX_WATER_MARK;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic [55:0] s_tdata = '0;   // [31:0] buf_addr, [55:32] fill_count
  logic [0:0]  s_tuser = '0;   // [0] func
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o; // [0] may_process, [1] sleep_request, rest zero

  // mirrored settings
  logic [23:0] mwm_reg;
  logic [15:0] timeout_reg;
  logic [15:0] interval_reg;
  logic [15:0] step_reg;

  // mirrored throttle state
  bft_pkg::mode_e cur_mode;
  logic [23:0] water_lo;
  logic [23:0] held_count;
  logic [31:0] held_addr;
  logic [16:0] slept_ms;
  logic [23:0] tap_a;
  logic [23:0] tap_b;
  logic [1:0]  taps_full;

  decision_t   decision_q [$];
  decision_t   want;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_reqs = 0;
  int unsigned n_results = 0;
  int unsigned n_learned = 0;
  int unsigned n_wraps = 0;
  int unsigned n_restarts = 0;
  int unsigned n_fail = 0;

  buffer_fill_throttle_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  // computes the decision for one request and advances the mirrored state
  task automatic throttle_decide(input logic func, input logic [31:0] addr,
                                 input logic [23:0] count, output decision_t dec);
    logic [15:0]        interval;
    logic signed [25:0] growth;
    logic signed [25:0] learned;
    logic [17:0]        slept_sum;
    logic [32:0]        end_now;
    logic [32:0]        end_held;
    logic [23:0]        lo;
    logic [23:0]        hi;
    logic [23:0]        med;
    dec = '0;
    interval = (interval_reg < timeout_reg) ? interval_reg : timeout_reg;
    growth = $signed({2'b00, count}) - $signed({2'b00, held_count});
    if (func == bft_pkg::FUNC_RESTART) begin
      cur_mode = bft_pkg::MODE_READY;
      water_lo = mwm_reg;
      taps_full = 2'b00;
      n_restarts++;
    end else begin
      case (cur_mode)
        bft_pkg::MODE_SLEEP: begin
          slept_sum = {1'b0, slept_ms} + {2'b00, step_reg};
          slept_ms = (slept_sum > 18'h1FFFF) ? 17'h1FFFF : slept_sum[16:0];
          if (slept_ms >= {1'b0, interval} && count == held_count && addr == held_addr) begin
            cur_mode = bft_pkg::MODE_WRAP;
            dec.may = 1'b1;
            n_wraps++;
          end else begin
            if (slept_ms >= {1'b0, timeout_reg} || growth > $signed({2'b00, mwm_reg})) begin
              learned = growth;
              if (learned > $signed({2'b00, mwm_reg}))
                learned = $signed({2'b00, mwm_reg});
              // lower clip wins when the upper bound sits below it
              if (learned < $signed({2'b00, bft_pkg::MinWaterMark}))
                learned = $signed({2'b00, bft_pkg::MinWaterMark});
              med = learned[23:0];
              if (taps_full == 2'b11) begin
                lo = (med < tap_a) ? med : tap_a;
                hi = (med < tap_a) ? tap_a : med;
                med = (lo > tap_b) ? lo : tap_b;
                med = (med < hi) ? med : hi;
              end
              tap_b = tap_a;
              tap_a = learned[23:0];
              taps_full = {taps_full[0], 1'b1};
              water_lo = med;
              cur_mode = bft_pkg::MODE_READY;
              n_learned++;
            end
            dec.slp = 1'b1;
          end
        end
        bft_pkg::MODE_WRAP: begin
          end_now = {1'b0, addr} + {9'b0, count};
          end_held = {1'b0, held_addr} + {9'b0, held_count};
          if (end_now != end_held) begin
            cur_mode = bft_pkg::MODE_READY;
          end else begin
            held_addr = addr;
            held_count = count;
            dec.may = 1'b1;
          end
        end
        default: begin
          if (count < water_lo) begin
            held_count = count;
            held_addr = addr;
            cur_mode = bft_pkg::MODE_SLEEP;
            slept_ms = '0;
            dec.slp = 1'b1;
          end else begin
            dec.may = 1'b1;
          end
        end
      endcase
    end
  endtask

  task automatic send_request(input logic func, input logic [31:0] addr,
                              input logic [23:0] count, input logic typed,
                              input decision_t typed_dec);
    decision_t dec;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {count, addr};
    s_tuser <= func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    throttle_decide(func, addr, count, dec);
    decision_q.push_back(typed ? typed_dec : dec);
    n_reqs++;
  endtask

  // mostly well-formed sleep / wrap sequences, plus restarts and noise
  task automatic pick_request(output logic func, output logic [31:0] addr,
                              output logic [23:0] count);
    int unsigned sel;
    logic [31:0] sum;
    logic [23:0] shift;
    sel = $urandom_range(99);
    func = bft_pkg::FUNC_FILL;
    addr = $urandom;
    count = 24'($urandom_range(24'hFFFFFF, 0));
    if (sel < 4) begin
      func = bft_pkg::FUNC_RESTART;
    end else if (sel < 14) begin
      case ($urandom_range(3))
        0: count = '0;
        1: count = '1;
        default: ;
      endcase
      case ($urandom_range(3))
        0: addr = '0;
        1: addr = '1;
        default: ;
      endcase
    end else if (sel < 34) begin
      addr = held_addr;
      count = held_count;
    end else if (sel < 44) begin
      // same data end, moved start
      shift = 24'($urandom_range(32'(held_count), 0));
      addr = held_addr + 32'(shift);
      count = held_count - shift;
    end else if (sel < 74) begin
      sum = 32'(held_count) + $urandom_range(32'(water_lo) + 1000, 0);
      count = (sum > 32'h00FF_FFFF) ? 24'hFFFFFF : sum[23:0];
      if ($urandom_range(3) != 0)
        addr = held_addr;
    end else begin
      count = (water_lo == '0) ? '0 : 24'($urandom_range(32'(water_lo) - 1, 0));
    end
  endtask

  task automatic load_settings(input logic [23:0] mwm, input logic [15:0] tmo,
                               input logic [15:0] ivl, input logic [15:0] stp);
    cfg_we <= 1'b1;
    cfg_idx <= bft_pkg::CFG_MAX_WATER_MARK;
    cfg_data <= mwm;
    @(posedge clk_i);
    mwm_reg = mwm;
    cfg_idx <= bft_pkg::CFG_TIMEOUT;
    cfg_data <= {8'h00, tmo};
    @(posedge clk_i);
    timeout_reg = tmo;
    cfg_idx <= bft_pkg::CFG_DATA_INTERVAL;
    cfg_data <= {8'h00, ivl};
    @(posedge clk_i);
    interval_reg = ivl;
    cfg_idx <= bft_pkg::CFG_SLEEP_STEP;
    cfg_data <= {8'h00, stp};
    @(posedge clk_i);
    step_reg = stp;
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      n_results++;
      if (decision_q.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result transfer, got tdata=%b", $time, m_axis_tdata_o);
      end else begin
        want = decision_q.pop_front();
        if (m_axis_tdata_o[0] !== want.may || m_axis_tdata_o[1] !== want.slp ||
            m_axis_tdata_o[7:2] !== 6'b0) begin
          n_fail++;
          $display("%0t: result %0d mismatch, expected may_process=%0b sleep_request=%0b,",
                   $time, n_results, want.may, want.slp);
          $display("%0t:   got tdata=%b", $time, m_axis_tdata_o);
        end
      end
    end
  end

  initial begin : stim
    logic        func;
    logic [31:0] addr;
    logic [23:0] count;
    mwm_reg = bft_pkg::MaxWaterMarkRst;
    timeout_reg = bft_pkg::TimeoutRst;
    interval_reg = bft_pkg::DataIntervalRst;
    step_reg = bft_pkg::SleepStepRst;
    cur_mode = bft_pkg::MODE_READY;
    water_lo = bft_pkg::MaxWaterMarkRst;
    held_count = '0;
    held_addr = '0;
    slept_ms = '0;
    tap_a = '0;
    tap_b = '0;
    taps_full = 2'b00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDir; i++)
      send_request(DirTbl[i].func, DirTbl[i].addr, DirTbl[i].count, DirTbl[i].typed,
                   {DirTbl[i].may, DirTbl[i].slp});
    s_tvalid <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      // settings change only once the block has drained
      while (decision_q.size() != 0) @(posedge clk_i);
      case (ph)
        0: load_settings(bft_pkg::MaxWaterMarkRst, bft_pkg::TimeoutRst,
                         bft_pkg::DataIntervalRst, bft_pkg::SleepStepRst);
        1: load_settings(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_settings(24'h000000, 16'h0000, 16'h0000, 16'h0001);
        3: load_settings(24'd5000, 16'd60, 16'd100, 16'd7);
        4: load_settings(24'd1000, 16'd30, 16'd10, 16'd3);
        5: load_settings(24'($urandom_range(20000, 0)), 16'($urandom_range(300, 0)),
                         16'($urandom_range(300, 0)), 16'($urandom_range(60, 1)));
        6: load_settings(24'($urandom_range(24'hFFFFFF, 0)), 16'($urandom_range(400, 0)),
                         16'($urandom_range(400, 0)), 16'($urandom_range(100, 1)));
        default: load_settings(bft_pkg::MinWaterMark, 16'd80, 16'd80, 16'd40);
      endcase
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int k = 0; k < ReqsPerPhase; k++) begin
        pick_request(func, addr, count);
        send_request(func, addr, count, 1'b0, '0);
      end
      s_tvalid <= 1'b0;
    end

    for (int w = 0; w < 20000 && decision_q.size() != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (decision_q.size() != 0) begin
      n_fail++;
      $display("%0t: %0d expected results never arrived", $time, decision_q.size());
    end
    $display("ran %0d requests over %0d setting phases with sender and receiver stalls",
             n_reqs, NumPhases);
    $display("model saw %0d learned watermarks, %0d wrap entries, %0d restarts",
             n_learned, n_wraps, n_restarts);
    if (n_fail == 0)
      $display("[buffer_fill_throttle_top] OK");
    else
      $display("[buffer_fill_throttle_top] ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, decision_q.size());
    $display("[buffer_fill_throttle_top] ERROR");
    $finish;
  end

endmodule
